@@ sv/bbl_pkg.sv @@
`timescale 1ns / 1ps

package bbl_pkg;

  // Default line buffer depth (widest frame)
  localparam int MAX_WIDTH_DFLT = 2048;

  // Field and register widths
  localparam int FW_W   = 12;
  localparam int FH_W   = 13;
  localparam int ROW_W  = 13;
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 13;

  // Register reset values and the height clamp
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;
  localparam int HEIGHT_LIMIT = 4096;

  // Averaging arithmetic: numerator is 2*sum+count, divisor 2*count
  localparam int SUM_W       = 12;
  localparam int NUM_W       = 13;
  localparam int CNT_W       = 4;
  localparam int RECIP_W     = 24;
  localparam int RECIP_SHIFT = 24;
  localparam int PROD_W      = NUM_W + RECIP_W;

  // Register indexes on the config port
  typedef enum logic [CFG_AW-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic       func;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_last;
  } out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // Where the output pixel sits against the frame border
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
    logic last;
  } pos_t;

  // Neighbors inside the frame, bit r*3+c for window row r, column c
  function automatic logic [8:0] win_mask(pos_t p);
    logic [8:0] m;
    m = '1;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((r == 0 && p.top) || (r == 2 && p.bottom) ||
            (c == 0 && p.left) || (c == 2 && p.right)) begin
          m[r*3+c] = 1'b0;
        end
      end
    end
    return m;
  endfunction

  // Count of neighbors inside the frame: 1, 2, 3, 4, 6 or 9
  function automatic logic [CNT_W-1:0] win_count(pos_t p);
    logic [1:0] rows;
    logic [1:0] cols;
    rows = 2'd3 - {1'b0, p.top} - {1'b0, p.bottom};
    cols = 2'd3 - {1'b0, p.left} - {1'b0, p.right};
    return CNT_W'(rows) * CNT_W'(cols);
  endfunction

  // ceil(2^24 / (2*count)); exact floor for numerators below 2^13
  function automatic logic [RECIP_W-1:0] recip(logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] m;
    case (cnt)
      4'd1:    m = 24'd8388608;
      4'd2:    m = 24'd4194304;
      4'd3:    m = 24'd2796203;
      4'd4:    m = 24'd2097152;
      4'd6:    m = 24'd1398102;
      4'd9:    m = 24'd932068;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

@@ sv/bbl_ram.sv @@
`timescale 1ns / 1ps

module bbl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Simple dual port, read returns old data on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/bbl_lane.sv @@
`timescale 1ns / 1ps

module bbl_lane (
  input  logic                     clk,
  input  logic                     ld,
  input  logic [8:0][7:0]          vals,
  input  logic [8:0]               mask,
  input  logic [bbl_pkg::CNT_W-1:0] cnt,
  output logic [7:0]               q
);

  import bbl_pkg::*;

  logic [SUM_W-1:0]  sum;
  logic [NUM_W-1:0]  num_nxt;
  logic [NUM_W-1:0]  num_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [PROD_W-1:0] prod;

  // Masked sum over the window, then the rounding numerator 2*sum+count
  always_comb begin
    sum = '0;
    for (int i = 0; i < 9; i++) begin
      if (mask[i]) begin
        sum = sum + SUM_W'(vals[i]);
      end
    end
    num_nxt = {sum, 1'b0} + NUM_W'(cnt);
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      num_r <= num_nxt;
      cnt_r <= cnt;
    end
  end

  // Divide by 2*count through its reciprocal
  assign prod = PROD_W'(num_r) * PROD_W'(recip(cnt_r));
  assign q    = prod[RECIP_SHIFT+7:RECIP_SHIFT];

endmodule

@@ sv/bbl_merge.sv @@
`timescale 1ns / 1ps

module bbl_merge (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          d_valid,
  output logic          d_ready,
  input  bbl_pkg::pix_t d_pix,
  input  logic          d_last,
  output logic          out_valid,
  input  logic          out_stall,
  output bbl_pkg::out_t out_data
);

  import bbl_pkg::*;

  logic out_valid_r;
  out_t out_data_r;
  logic load;

  // Output register frees up when empty or taken this cycle
  assign d_ready = !out_valid_r || !out_stall;
  assign load    = d_valid && d_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (d_ready) begin
      out_valid_r <= d_valid;
    end
  end

  // Gather the three channel lanes and the end-of-frame flag
  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.red_out    <= d_pix.red;
      out_data_r.green_out  <= d_pix.green;
      out_data_r.blue_out   <= d_pix.blue;
      out_data_r.frame_last <= d_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ sv/rgb_box_blur_3x3.sv @@
`timescale 1ns / 1ps
// Throughput: one word per cycle, in and out, while neither side stalls.
// Pipeline: the word that completes a result's 3x3 window, width+1 words after
// its own pixel, passes stage B, the window, the lane numerators, the output register.
// Line buffers are one read and one write per word (two RAMs, registered read).
// Synchronous active-low reset clears counters, window and valids; registers
// return to 640 x 480; line buffer contents are left as they are.

module rgb_box_blur_3x3 #(
  parameter int MAX_WIDTH = bbl_pkg::MAX_WIDTH_DFLT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  bbl_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output bbl_pkg::out_t              out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bbl_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [bbl_pkg::CFG_DW-1:0] cfg_data
);

  import bbl_pkg::*;

  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CMPW  = (WW > FW_W) ? WW : FW_W;
  localparam int RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

  // Effective frame size, clamped at write time
  logic [WW-1:0]    w_eff_r;
  logic [FH_W-1:0]  h_eff_r;
  logic [CMPW-1:0]  fw_ext;
  logic [WW-1:0]    w_nxt;
  logic [FH_W-1:0]  h_nxt;

  // Input position
  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  // Handshake chain
  logic accept, cfg_wr, cfg_hit;
  logic ready_b, ready_c, ready_d, ready_o;
  logic b_adv, ld_d, d_adv;

  // Stage B: word waiting on the line buffer read
  logic             vb_r;
  logic             has_b_r;
  pos_t             pos_b_r;
  pix_t             px_b_r;
  logic [CW-1:0]    col_b_r;
  logic             byp_r;
  pix_t             byp_up_r, byp_mid_r;
  pix_t             up_q, mid_q, up_rd, mid_rd;

  // Stage C: window holding a complete neighborhood
  logic                  vc_r;
  pos_t                  pos_c_r;
  pix_t [2:0][2:0]       window_r, window_nxt;
  logic [8:0]            mask_c;
  logic [CNT_W-1:0]      cnt_c;
  logic [2:0][8:0][7:0]  lane_vals;
  logic [2:0][7:0]       lane_q;

  // Stage D: lane numerators registered
  logic vd_r;
  logic last_d_r;
  pix_t d_pix;

  // Position of the output pixel for the word at the input
  logic             has_a;
  pos_t             pos_a;
  logic [ROW_W-1:0] orow;
  logic [WW-1:0]    ocol, wm1, col_p1;
  pix_t             px_a;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  // Only writes to a known register restart the frame
  assign cfg_hit   = cfg_wr && (cfg_addr inside {REG_FRAME_WIDTH, REG_FRAME_HEIGHT});

  // Clamp register writes to the supported range
  always_comb begin
    fw_ext = CMPW'(cfg_data[FW_W-1:0]);
    if (fw_ext == '0) begin
      w_nxt = WW'(1);
    end else if (fw_ext > CMPW'(MAX_WIDTH)) begin
      w_nxt = WW'(MAX_WIDTH);
    end else begin
      w_nxt = WW'(fw_ext);
    end
    if (cfg_data == '0) begin
      h_nxt = FH_W'(1);
    end else if (cfg_data > FH_W'(HEIGHT_LIMIT)) begin
      h_nxt = FH_W'(HEIGHT_LIMIT);
    end else begin
      h_nxt = cfg_data;
    end
  end

  // Pipeline advance, back from the output register
  assign ready_d  = !vd_r || ready_o;
  assign d_adv    = vd_r && ready_o;
  assign ready_c  = !vc_r || ready_d;
  assign ld_d     = vc_r && ready_d;
  assign ready_b  = !vb_r || ready_c;
  assign b_adv    = vb_r && ready_c;
  assign in_stall = !ready_b;
  assign accept   = in_valid && ready_b;

  // Output position and border flags from the input counters
  always_comb begin
    wm1    = w_eff_r - WW'(1);
    col_p1 = WW'(col_r) + WW'(1);
    if (col_r == '0) begin
      has_a = row_r >= ROW_W'(2);
      orow  = row_r - ROW_W'(2);
      ocol  = wm1;
    end else begin
      has_a = row_r >= ROW_W'(1);
      orow  = row_r - ROW_W'(1);
      ocol  = WW'(col_r) - WW'(1);
    end
    has_a        = has_a && (orow < h_eff_r);
    pos_a.top    = orow == '0;
    pos_a.bottom = orow == h_eff_r - FH_W'(1);
    pos_a.left   = ocol == '0;
    pos_a.right  = ocol == wm1;
    pos_a.last   = has_a && pos_a.bottom && pos_a.right;
    px_a         = in_data.func ? '0 :
                   {in_data.red_in, in_data.green_in, in_data.blue_in};
  end

  // Next input position; the end of a frame or a known register write starts the next one
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (pos_a.last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_p1 >= w_eff_r) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_p1[CW-1:0];
      end
    end
  end

  // Line buffers: upper takes the old middle, middle takes the new word
  bbl_ram #(.WIDTH($bits(pix_t)), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (b_adv),
    .waddr (col_b_r),
    .wdata (mid_rd),
    .re    (accept),
    .raddr (col_r),
    .rdata (up_q)
  );

  bbl_ram #(.WIDTH($bits(pix_t)), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (b_adv),
    .waddr (col_b_r),
    .wdata (px_b_r),
    .re    (accept),
    .raddr (col_r),
    .rdata (mid_q)
  );

  // Forward the write that lands on the address read in the same cycle
  assign up_rd  = byp_r ? byp_up_r : up_q;
  assign mid_rd = byp_r ? byp_mid_r : mid_q;

  // Window shifts left one column per word
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      window_nxt[r][0] = window_r[r][1];
      window_nxt[r][1] = window_r[r][2];
    end
    window_nxt[0][2] = up_rd;
    window_nxt[1][2] = mid_rd;
    window_nxt[2][2] = px_b_r;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r  <= WW'(RST_W);
      h_eff_r  <= FH_W'(RESET_HEIGHT);
      col_r    <= '0;
      row_r    <= '0;
      vb_r     <= 1'b0;
      vc_r     <= 1'b0;
      vd_r     <= 1'b0;
      window_r <= '0;
    end else begin
      if (cfg_wr && cfg_addr == REG_FRAME_WIDTH) begin
        w_eff_r <= w_nxt;
      end
      if (cfg_wr && cfg_addr == REG_FRAME_HEIGHT) begin
        h_eff_r <= h_nxt;
      end
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (ready_b) begin
        vb_r <= accept;
      end
      if (ready_c) begin
        vc_r <= b_adv && has_b_r;
      end
      if (ready_d) begin
        vd_r <= ld_d;
      end
      if (b_adv) begin
        window_r <= window_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      has_b_r <= has_a;
      pos_b_r <= pos_a;
      px_b_r  <= px_a;
      col_b_r <= col_r;
      byp_r   <= vb_r && (col_b_r == col_r);
    end
    if (b_adv) begin
      byp_up_r  <= mid_rd;
      byp_mid_r <= px_b_r;
      pos_c_r   <= pos_b_r;
    end
    if (ld_d) begin
      last_d_r <= pos_c_r.last;
    end
  end

  // One lane per color channel
  assign mask_c = win_mask(pos_c_r);
  assign cnt_c  = win_count(pos_c_r);

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        lane_vals[0][r*3+c] = window_r[r][c].red;
        lane_vals[1][r*3+c] = window_r[r][c].green;
        lane_vals[2][r*3+c] = window_r[r][c].blue;
      end
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    bbl_lane u_lane (
      .clk  (clk),
      .ld   (ld_d),
      .vals (lane_vals[ch]),
      .mask (mask_c),
      .cnt  (cnt_c),
      .q    (lane_q[ch])
    );
  end

  assign d_pix = {lane_q[0], lane_q[1], lane_q[2]};

  bbl_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .d_valid   (d_adv),
    .d_ready   (ready_o),
    .d_pix     (d_pix),
    .d_last    (last_d_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Column counter stays inside the frame
  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(col_r) < w_eff_r)
    else $error("input column beyond frame width");

  // Row counter never exceeds the frame height plus one
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, row_r} <= {1'b0, h_eff_r} + (FH_W+1)'(1))
    else $error("input row beyond drain rows");

  // Last pixel of a frame restarts the position counters
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && pos_a.last) |=> (col_r == '0 && row_r == '0))
    else $error("counters not restarted after frame end");

  // Window holds while its neighborhood waits on the lanes
  a_window_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vc_r && !ready_d) |=> $stable(window_r))
    else $error("window moved under a stalled result");

endmodule

@@ tb/tb_rgb_box_blur_3x3.sv @@
`timescale 1ns / 1ps

module tb_rgb_box_blur_3x3;
  import bbl_pkg::*;

  localparam int MAX_W      = MAX_WIDTH_DFLT;
  localparam int SETTLE_CYC = 8;
  localparam int CYCLE_CAP  = 600000;
  localparam int PHASE_WORDS = 250;
  localparam int SHORT_RUN   = 24;

  // Directed stimulus rows: a register write or one input word
  typedef enum logic [1:0] {
    DO_WORD,
    DO_WIDTH,
    DO_HEIGHT
  } step_kind_t;

  typedef struct packed {
    step_kind_t            kind;
    logic [CFG_DW-1:0]     value;
    in_t                   word;
    logic                  typed;
    out_t                  want;
  } step_row_t;

  localparam in_t  WHITE = '{1'b0, 8'hFF, 8'hFF, 8'hFF};
  localparam in_t  DRAIN = '{1'b1, 8'h00, 8'h00, 8'h00};
  localparam in_t  NONE  = '0;
  localparam out_t NOOUT = '0;

  localparam step_row_t DIR_TAB [32] = '{
    // 1x1 frame: the pixel comes back as it is, flagged last
    '{DO_WIDTH,  13'd1, NONE,  1'b0, NOOUT},
    '{DO_HEIGHT, 13'd1, NONE,  1'b0, NOOUT},
    '{DO_WORD,   13'd0, WHITE, 1'b0, NOOUT},
    '{DO_WORD,   13'd0, DRAIN, 1'b0, NOOUT},
    '{DO_WORD,   13'd0, DRAIN, 1'b1, '{8'd255, 8'd255, 8'd255, 1'b1}},
    // 2x2 frame, flush inside the frame is black; every pixel sees all four
    '{DO_WIDTH,  13'd2, NONE,  1'b0, NOOUT},
    '{DO_HEIGHT, 13'd2, NONE,  1'b0, NOOUT},
    '{DO_WORD,   13'd0, '{1'b0, 8'h00, 8'hFF, 8'h80}, 1'b0, NOOUT},
    '{DO_WORD,   13'd0, WHITE, 1'b0, NOOUT},
    '{DO_WORD,   13'd0, DRAIN, 1'b0, NOOUT},
    '{DO_WORD,   13'd0, '{1'b0, 8'h01, 8'h80, 8'h7F}, 1'b1, '{8'd64, 8'd160, 8'd128, 1'b0}},
    '{DO_WORD,   13'd0, DRAIN, 1'b1, '{8'd64, 8'd160, 8'd128, 1'b0}},
    '{DO_WORD,   13'd0, DRAIN, 1'b1, '{8'd64, 8'd160, 8'd128, 1'b0}},
    '{DO_WORD,   13'd0, DRAIN, 1'b1, '{8'd64, 8'd160, 8'd128, 1'b1}},
    // 3x1 frame; pixels sent during the drain must be masked
    '{DO_WIDTH,  13'd3, NONE,  1'b0, NOOUT},
    '{DO_HEIGHT, 13'd1, NONE,  1'b0, NOOUT},
    '{DO_WORD,   13'd0, '{1'b0, 8'hFF, 8'h00, 8'h00}, 1'b0, NOOUT},
    '{DO_WORD,   13'd0, '{1'b0, 8'h00, 8'hFF, 8'h00}, 1'b0, NOOUT},
    '{DO_WORD,   13'd0, '{1'b0, 8'h00, 8'h00, 8'hFF}, 1'b0, NOOUT},
    '{DO_WORD,   13'd0, DRAIN, 1'b0, NOOUT},
    '{DO_WORD,   13'd0, WHITE, 1'b1, '{8'd128, 8'd128, 8'd0, 1'b0}},
    '{DO_WORD,   13'd0, WHITE, 1'b1, '{8'd85, 8'd85, 8'd85, 1'b0}},
    '{DO_WORD,   13'd0, DRAIN, 1'b1, '{8'd0, 8'd128, 8'd128, 1'b1}},
    // frame cut short by a width write, then a clean 2x1 frame
    '{DO_WIDTH,  13'd4, NONE,  1'b0, NOOUT},
    '{DO_WORD,   13'd0, '{1'b0, 8'h5A, 8'hA5, 8'h3C}, 1'b0, NOOUT},
    '{DO_WORD,   13'd0, '{1'b0, 8'hC3, 8'h3C, 8'h99}, 1'b0, NOOUT},
    '{DO_WIDTH,  13'd2, NONE,  1'b0, NOOUT},
    '{DO_WORD,   13'd0, '{1'b0, 8'd10, 8'd20, 8'd30}, 1'b0, NOOUT},
    '{DO_WORD,   13'd0, '{1'b0, 8'd11, 8'd21, 8'd31}, 1'b0, NOOUT},
    '{DO_WORD,   13'd0, DRAIN, 1'b0, NOOUT},
    '{DO_WORD,   13'd0, DRAIN, 1'b1, '{8'd11, 8'd21, 8'd31, 1'b0}},
    '{DO_WORD,   13'd0, DRAIN, 1'b1, '{8'd11, 8'd21, 8'd31, 1'b1}}
  };

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_t               in_data;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_t              out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_data;

  rgb_box_blur_3x3 dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Blur predictor state
  bit [23:0]         upper_mem  [MAX_W];
  bit [23:0]         middle_mem [MAX_W];
  bit [23:0]         win [3][3];
  int                col_q;
  int                row_q;
  logic [FW_W-1:0]   fw_q;
  logic [FH_W-1:0]   fh_q;

  out_t blur_q [$];

  int send_gap_pct;
  int recv_stall_pct;
  int fail_cnt;
  int words_sent;
  int pixels_seen;
  int frames_seen;
  int reg_writes;
  int cycle_cnt;

  function automatic int eff_w();
    return (fw_q == 0) ? 1 : (int'(fw_q) > MAX_W) ? MAX_W : int'(fw_q);
  endfunction

  function automatic int eff_h();
    return (fh_q == 0) ? 1 : (int'(fh_q) > HEIGHT_LIMIT) ? HEIGHT_LIMIT : int'(fh_q);
  endfunction

  // Advance the window by one word; returns 1 when a blurred pixel leaves
  function automatic bit blur_step(input in_t word, output out_t res);
    bit [23:0] px;
    bit [23:0] v;
    int        wd, ht, idx, orow, ocol, cnt, sr, sg, sb;
    bit        has;
    bit        last;
    wd   = eff_w();
    ht   = eff_h();
    px   = word.func ? 24'd0 : {word.red_in, word.green_in, word.blue_in};
    idx  = (col_q < MAX_W) ? col_q : MAX_W - 1;
    has  = 1'b0;
    last = 1'b0;
    orow = 0;
    ocol = 0;
    res  = '0;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2]       = upper_mem[idx];
    win[1][2]       = middle_mem[idx];
    win[2][2]       = px;
    upper_mem[idx]  = middle_mem[idx];
    middle_mem[idx] = px;
    // output pixel sits one row up and one column left of the input (two rows up, last column, at column 0)
    if (col_q == 0) begin
      if (row_q >= 2) begin
        has  = 1'b1;
        orow = row_q - 2;
        ocol = wd - 1;
      end
    end else if (row_q >= 1) begin
      has  = 1'b1;
      orow = row_q - 1;
      ocol = col_q - 1;
    end
    if (has && orow >= ht) has = 1'b0;
    if (has) begin
      cnt = 0;
      sr  = 0;
      sg  = 0;
      sb  = 0;
      for (int r = 0; r < 3; r++) begin
        if (r == 0 && orow == 0) continue;
        if (r == 2 && orow + 1 >= ht) continue;
        for (int c = 0; c < 3; c++) begin
          if (c == 0 && ocol == 0) continue;
          if (c == 2 && ocol + 1 >= wd) continue;
          v = win[r][c];
          sr += v[23:16];
          sg += v[15:8];
          sb += v[7:0];
          cnt++;
        end
      end
      // round half up
      res.red_out    = 8'((2 * sr + cnt) / (2 * cnt));
      res.green_out  = 8'((2 * sg + cnt) / (2 * cnt));
      res.blue_out   = 8'((2 * sb + cnt) / (2 * cnt));
      last           = (orow == ht - 1) && (ocol == wd - 1);
      res.frame_last = last;
    end
    col_q++;
    if (col_q >= wd) begin
      col_q = 0;
      row_q = (row_q + 1) & 13'h1FFF;
    end
    if (last) begin
      col_q = 0;
      row_q = 0;
    end
    return has;
  endfunction

  // Send one word; caller is at a falling edge and stays responsible for in_valid
  task automatic push_word(input in_t word, input bit typed, input out_t want);
    out_t guess;
    bit   has;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    has = blur_step(word, guess);
    if (typed) blur_q.push_back(want);
    else if (has) blur_q.push_back(guess);
    words_sent++;
    @(negedge clk);
  endtask

  // Stop sending and let every expected pixel come out
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (blur_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DW-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_FRAME_WIDTH) fw_q = value[FW_W-1:0];
    else fh_q = value[FH_W-1:0];
    col_q = 0;
    row_q = 0;
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_t rand_word(input bit flush);
    in_t w;
    w      = in_t'($urandom);
    w.func = flush;
    return w;
  endfunction

  // One frame plus its drain; noisy frames may cut short or send pixels in the drain
  // A nonzero limit caps the words sent
  bit paused;

  task automatic run_frame(input int wd_set, input int ht_set, input bit rewrite,
                           input bit noisy, input int limit);
    int wd, ht, area, n, cut;
    in_t word;
    if (rewrite) begin
      write_reg(REG_FRAME_WIDTH, CFG_DW'(wd_set));
      write_reg(REG_FRAME_HEIGHT, CFG_DW'(ht_set));
    end
    wd   = eff_w();
    ht   = eff_h();
    area = wd * ht;
    n    = area + wd + 1;
    cut  = (noisy && $urandom_range(9) == 0) ? $urandom_range(1, n - 1) : n;
    if (limit > 0 && cut > limit) cut = limit;
    for (int i = 0; i < cut; i++) begin
      if (noisy && !paused && cut >= 4 && i == cut / 2) begin
        settle();
        paused = 1'b1;
      end
      if (i < area) word = rand_word($urandom_range(15) == 0);
      else word = rand_word(!(noisy && $urandom_range(7) == 0));
      push_word(word, 1'b0, NOOUT);
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      pixels_seen++;
      if (out_data.frame_last) frames_seen++;
      if (blur_q.size() == 0) begin
        $error("unexpected blurred pixel %h", out_data);
        fail_cnt++;
      end else begin
        want = blur_q.pop_front();
        if (out_data.red_out !== want.red_out) begin
          $error("red_out: expected %0d, actual %0d", want.red_out, out_data.red_out);
          fail_cnt++;
        end
        if (out_data.green_out !== want.green_out) begin
          $error("green_out: expected %0d, actual %0d", want.green_out, out_data.green_out);
          fail_cnt++;
        end
        if (out_data.blue_out !== want.blue_out) begin
          $error("blue_out: expected %0d, actual %0d", want.blue_out, out_data.blue_out);
          fail_cnt++;
        end
        if (out_data.frame_last !== want.frame_last) begin
          $error("frame_last: expected %0d, actual %0d", want.frame_last,
                 out_data.frame_last);
          fail_cnt++;
        end
      end
    end
  end

  // Receiver backpressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_CAP) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int base;
    int wd_set, ht_set;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_valid      = 1'b0;
    cfg_addr       = '0;
    cfg_data       = '0;
    send_gap_pct   = 20;
    recv_stall_pct = 67;
    fail_cnt       = 0;
    words_sent     = 0;
    pixels_seen    = 0;
    frames_seen    = 0;
    reg_writes     = 0;
    cycle_cnt      = 0;
    fw_q           = FW_W'(RESET_WIDTH);
    fh_q           = FH_W'(RESET_HEIGHT);
    col_q          = 0;
    row_q          = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed rows
    foreach (DIR_TAB[i]) begin
      case (DIR_TAB[i].kind)
        DO_WIDTH:  write_reg(REG_FRAME_WIDTH, DIR_TAB[i].value);
        DO_HEIGHT: write_reg(REG_FRAME_HEIGHT, DIR_TAB[i].value);
        default:   push_word(DIR_TAB[i].word, DIR_TAB[i].typed, DIR_TAB[i].want);
      endcase
    end

    // Random frames over three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      send_gap_pct   = (ph == 0) ? 20 : (ph == 1) ? 67 : 0;
      recv_stall_pct = (ph == 0) ? 67 : (ph == 1) ? 20 : 0;
      paused         = 1'b0;
      base           = words_sent;
      while (words_sent < base + PHASE_WORDS) begin
        wd_set = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        ht_set = $urandom_range(0, 6);
        run_frame(wd_set, ht_set, $urandom_range(2) != 0, 1'b1, 0);
      end
    end

    // Size extremes: large and clamped sizes on short runs, zero sizes in full
    run_frame(2048, 2, 1'b1, 1'b0, SHORT_RUN);
    run_frame(4095, 1, 1'b1, 1'b0, SHORT_RUN);
    run_frame(1, 4096, 1'b1, 1'b0, SHORT_RUN);
    run_frame(1, 8191, 1'b1, 1'b0, SHORT_RUN);
    run_frame(0, 0, 1'b1, 1'b0, 0);
    run_frame(0, 3, 1'b1, 1'b0, 0);
    run_frame(5, 0, 1'b1, 1'b0, 0);

    settle();
    repeat (20) @(negedge clk);
    $display("Blur run: %0d words sent, %0d blurred pixels checked, %0d frame ends, %0d writes.",
             words_sent, pixels_seen, frames_seen, reg_writes);
    $display("Frames up to 40 wide and 6 tall, zero sizes, short runs at clamped sizes.");
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
